FILE: hdl/escdec_pkg.sv
// Shared types, character codes and helpers for the escape sequence decoder.
`timescale 1ns / 1ps

package escdec_pkg;

   // Raw character store of an open hex escape (letter plus digits)
   localparam int RawDepth   = 8;
   localparam int RawIdxW    = $clog2(RawDepth);
   localparam int RawCntW    = $clog2(RawDepth + 1);

   // Command queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Beat counter covers backslash, full raw store and two characters
   localparam int BeatW      = 4;

   // Digit limits
   localparam logic [3:0] DecDigits   = 4'd3;
   localparam logic [3:0] HexDigitsLo = 4'd4;
   localparam logic [3:0] HexDigitsHi = 4'd8;

   // Character codes
   localparam logic [31:0] CharBackslash = 32'h0000_005C;
   localparam logic [31:0] CharLowerT    = 32'h0000_0074;
   localparam logic [31:0] CharLowerR    = 32'h0000_0072;
   localparam logic [31:0] CharLowerN    = 32'h0000_006E;
   localparam logic [31:0] CharLowerU    = 32'h0000_0075;
   localparam logic [31:0] CharUpperU    = 32'h0000_0055;
   localparam logic [31:0] CharTab       = 32'h0000_0009;
   localparam logic [31:0] CharCr        = 32'h0000_000D;
   localparam logic [31:0] CharLf        = 32'h0000_000A;

   typedef enum logic [1:0] {
      ModeIdle,
      ModeBsl,
      ModeHex,
      ModeDec
   } mode_type;

   // One queued command: raw flush, then up to two characters
   typedef struct packed {
      logic                          text_end;
      logic [BeatW-1:0]              flush_len;
      logic [BeatW-1:0]              last_beat;
      logic [RawDepth-1:0][7:0]      raw;
      logic [31:0]                   char_a;
      logic [31:0]                   char_b;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_dec_digit(input logic [31:0] c);
      return (c >= 32'h0000_0030) && (c <= 32'h0000_0039);
   endfunction

   function automatic logic is_hex_digit(input logic [31:0] c);
      return is_dec_digit(c) ||
             ((c >= 32'h0000_0041) && (c <= 32'h0000_0046)) ||
             ((c >= 32'h0000_0061) && (c <= 32'h0000_0066));
   endfunction

   // Nibble of a hex digit; letters sit at low code 1..6 in both cases
   function automatic logic [3:0] hex_nibble(input logic [31:0] c);
      if (is_dec_digit(c)) begin
         return c[3:0];
      end
      return 4'(c[3:0] + 4'd9);
   endfunction

endpackage

FILE: hdl/escdec_front.sv
// Front end: accepts characters, tracks the escape state and builds output commands.
`timescale 1ns / 1ps

module escdec_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [31:0]                   req_in_char,
   input  logic                          req_end_of_text,
   input  escdec_pkg::queue_status_type  q_status,
   output logic                          cmd_push,
   output escdec_pkg::cmd_type           cmd
);

   escdec_pkg::mode_type mode_ff, mode_in, mode_mid;
   logic [31:0]                  acc_ff, acc_in;
   logic [3:0]                   dig_ff, dig_in;
   logic [escdec_pkg::RawCntW-1:0] rc_ff, rc_in;
   logic [7:0]                   raw_ff [escdec_pkg::RawDepth];

   logic                         accept;
   logic                         is_bsl, is_dec, is_hex;
   logic [3:0]                   nib;
   logic                         raw_we;
   logic [escdec_pkg::RawIdxW-1:0] raw_wa;
   logic [7:0]                   raw_wd;
   logic [escdec_pkg::BeatW-1:0] flen;
   logic [1:0]                   nchar;
   logic [31:0]                  ca, cb;
   logic                         brk;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Classify the incoming character
   assign is_bsl = (req_in_char == escdec_pkg::CharBackslash);
   assign is_dec = escdec_pkg::is_dec_digit(req_in_char);
   assign is_hex = escdec_pkg::is_hex_digit(req_in_char);
   assign nib    = escdec_pkg::hex_nibble(req_in_char);

   // Next escape mode, before and after end-of-text closing
   always_comb begin
      mode_mid = mode_ff;
      if (accept) begin
         unique case (mode_ff)
            escdec_pkg::ModeIdle: begin
               mode_mid = is_bsl ? escdec_pkg::ModeBsl : escdec_pkg::ModeIdle;
            end
            escdec_pkg::ModeBsl: begin
               if (req_in_char == escdec_pkg::CharLowerU ||
                   req_in_char == escdec_pkg::CharUpperU) begin
                  mode_mid = escdec_pkg::ModeHex;
               end else if (is_dec) begin
                  mode_mid = escdec_pkg::ModeDec;
               end else begin
                  mode_mid = escdec_pkg::ModeIdle;
               end
            end
            escdec_pkg::ModeHex: begin
               if (is_hex) begin
                  mode_mid = (dig_ff == 4'd1) ? escdec_pkg::ModeIdle : escdec_pkg::ModeHex;
               end else begin
                  mode_mid = is_bsl ? escdec_pkg::ModeBsl : escdec_pkg::ModeIdle;
               end
            end
            escdec_pkg::ModeDec: begin
               if (is_dec) begin
                  mode_mid = (dig_ff == 4'd1) ? escdec_pkg::ModeIdle : escdec_pkg::ModeDec;
               end else begin
                  mode_mid = is_bsl ? escdec_pkg::ModeBsl : escdec_pkg::ModeIdle;
               end
            end
         endcase
      end
      mode_in = (accept && req_end_of_text) ? escdec_pkg::ModeIdle : mode_mid;
   end

   // Datapath and command content for the accepted character
   always_comb begin
      acc_in = acc_ff;
      dig_in = dig_ff;
      rc_in  = rc_ff;
      raw_we = 1'b0;
      raw_wa = rc_ff[escdec_pkg::RawIdxW-1:0];
      raw_wd = req_in_char[7:0];
      flen   = '0;
      nchar  = 2'd0;
      ca     = '0;
      cb     = '0;
      brk    = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            escdec_pkg::ModeIdle: begin
               brk = 1'b1;
            end
            escdec_pkg::ModeBsl: begin
               if (req_in_char == escdec_pkg::CharLowerT) begin
                  ca = escdec_pkg::CharTab;
                  nchar = 2'd1;
               end else if (req_in_char == escdec_pkg::CharLowerR) begin
                  ca = escdec_pkg::CharCr;
                  nchar = 2'd1;
               end else if (req_in_char == escdec_pkg::CharLowerN) begin
                  ca = escdec_pkg::CharLf;
                  nchar = 2'd1;
               end else if (req_in_char == escdec_pkg::CharLowerU ||
                            req_in_char == escdec_pkg::CharUpperU) begin
                  acc_in = '0;
                  dig_in = (req_in_char == escdec_pkg::CharLowerU) ?
                           escdec_pkg::HexDigitsLo : escdec_pkg::HexDigitsHi;
                  raw_we = 1'b1;
                  raw_wa = '0;
                  rc_in  = escdec_pkg::RawCntW'(1);
               end else if (is_dec) begin
                  acc_in = {28'd0, nib};
                  dig_in = escdec_pkg::DecDigits - 4'd1;
               end else begin
                  ca = req_in_char;
                  nchar = 2'd1;
               end
            end
            escdec_pkg::ModeHex: begin
               if (is_hex) begin
                  acc_in = {acc_ff[27:0], nib};
                  if (rc_ff < escdec_pkg::RawCntW'(escdec_pkg::RawDepth)) begin
                     raw_we = 1'b1;
                     rc_in  = rc_ff + escdec_pkg::RawCntW'(1);
                  end
                  dig_in = dig_ff - 4'd1;
                  if (dig_ff == 4'd1) begin
                     ca     = acc_in;
                     nchar  = 2'd1;
                     acc_in = '0;
                     dig_in = '0;
                     rc_in  = '0;
                  end
               end else begin
                  // Broken escape: backslash plus stored raw characters
                  flen   = escdec_pkg::BeatW'(rc_ff) + escdec_pkg::BeatW'(1);
                  acc_in = '0;
                  dig_in = '0;
                  rc_in  = '0;
                  brk    = 1'b1;
               end
            end
            escdec_pkg::ModeDec: begin
               if (is_dec) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + {28'd0, nib};
                  dig_in = dig_ff - 4'd1;
                  if (dig_ff == 4'd1) begin
                     ca     = acc_in;
                     nchar  = 2'd1;
                     acc_in = '0;
                     dig_in = '0;
                  end
               end else begin
                  ca     = acc_ff;
                  nchar  = 2'd1;
                  acc_in = '0;
                  dig_in = '0;
                  brk    = 1'b1;
               end
            end
         endcase

         // Handle the character from idle after a break
         if (brk && !is_bsl) begin
            if (nchar == 2'd0) ca = req_in_char;
            else cb = req_in_char;
            nchar = nchar + 2'd1;
         end

         // Close any open escape at end of text
         if (req_end_of_text) begin
            unique case (mode_mid)
               escdec_pkg::ModeBsl: begin
                  if (nchar == 2'd0) ca = escdec_pkg::CharBackslash;
                  else cb = escdec_pkg::CharBackslash;
                  nchar = nchar + 2'd1;
               end
               escdec_pkg::ModeHex: begin
                  flen = escdec_pkg::BeatW'(rc_in) + escdec_pkg::BeatW'(1);
               end
               escdec_pkg::ModeDec: begin
                  if (nchar == 2'd0) ca = acc_in;
                  else cb = acc_in;
                  nchar = nchar + 2'd1;
               end
               escdec_pkg::ModeIdle: begin
               end
            endcase
            acc_in = '0;
            dig_in = '0;
            rc_in  = '0;
         end
      end
   end

   // Assemble the command, raw store seen with this cycle's write
   always_comb begin
      cmd.text_end  = req_end_of_text;
      cmd.flush_len = flen;
      cmd.last_beat = flen + escdec_pkg::BeatW'(nchar) - escdec_pkg::BeatW'(1);
      cmd.char_a    = ca;
      cmd.char_b    = cb;
      for (int i = 0; i < escdec_pkg::RawDepth; i++) begin
         cmd.raw[i] = (raw_we && raw_wa == escdec_pkg::RawIdxW'(i)) ? raw_wd : raw_ff[i];
      end
   end

   assign cmd_push = accept && ((flen != '0) || (nchar != 2'd0));

   // Escape state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= escdec_pkg::ModeIdle;
         acc_ff  <= '0;
         dig_ff  <= '0;
         rc_ff   <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         dig_ff  <= dig_in;
         rc_ff   <= rc_in;
      end
   end

   // Raw character store, no reset
   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_ff[raw_wa] <= raw_wd;
      end
   end

endmodule

FILE: hdl/escdec_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module escdec_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  escdec_pkg::cmd_type           push_cmd,
   input  logic                          pop,
   output escdec_pkg::cmd_type           head_cmd,
   output escdec_pkg::queue_status_type  status
);

   escdec_pkg::cmd_type entry_ff [escdec_pkg::QueueDepth];
   logic [escdec_pkg::QueuePtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [escdec_pkg::QueueCntW-1:0] cnt_ff, cnt_in;

   assign head_cmd     = entry_ff[rd_ff];
   assign status.full  = (cnt_ff == escdec_pkg::QueueCntW'(escdec_pkg::QueueDepth));
   assign status.empty = (cnt_ff == '0);

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == escdec_pkg::QueuePtrW'(escdec_pkg::QueueDepth - 1)) ?
                 '0 : wr_ff + escdec_pkg::QueuePtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == escdec_pkg::QueuePtrW'(escdec_pkg::QueueDepth - 1)) ?
                 '0 : rd_ff + escdec_pkg::QueuePtrW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + escdec_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - escdec_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/escdec_back.sv
// Back end: expands queued commands into output beats behind an output register.
`timescale 1ns / 1ps

module escdec_back (
   input  logic                          clock,
   input  logic                          reset,
   input  escdec_pkg::cmd_type           head_cmd,
   input  escdec_pkg::queue_status_type  q_status,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_out_char,
   output logic                          rsp_run_last,
   output logic                          rsp_text_done
);

   logic [escdec_pkg::BeatW-1:0] beat_ff, beat_in;
   logic        valid_ff, valid_in;
   logic [31:0] char_ff, char_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;
   logic        load;

   assign load = !q_status.empty && (!valid_ff || !rsp_stall);

   // Select the character of the current beat
   always_comb begin
      if (beat_ff < head_cmd.flush_len) begin
         if (beat_ff == '0) begin
            char_in = escdec_pkg::CharBackslash;
         end else begin
            char_in = {24'd0,
                       head_cmd.raw[escdec_pkg::RawIdxW'(beat_ff - escdec_pkg::BeatW'(1))]};
         end
      end else if (beat_ff == head_cmd.flush_len) begin
         char_in = head_cmd.char_a;
      end else begin
         char_in = head_cmd.char_b;
      end
      last_in = (beat_ff == head_cmd.last_beat);
      done_in = last_in && head_cmd.text_end;
   end

   // Advance the beat counter; drop the command after its last beat
   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = last_in ? '0 : beat_ff + escdec_pkg::BeatW'(1);
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign cmd_pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload, held while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_text_done = done_ff;

endmodule

FILE: hdl/escape_sequence_decoder_core.sv
// Top level of the backslash escape decoder: front end, command queue, back end.
`timescale 1ns / 1ps

// Channel  Ports                                         Direction
// req      req_valid, req_stall, req_in_char,
//          req_end_of_text                               in (stall out)
// rsp      rsp_valid, rsp_stall, rsp_out_char,
//          rsp_run_last, rsp_text_done                   out (stall in)
//
// One character is taken per cycle while the command queue is not full; the back end
// sends an item's beats out in order, so an item that yields k beats (up to 10 on a
// broken hex escape) holds the back end while the four-entry queue absorbs the burst.
// An accepted item's first beat goes to rsp via a queue entry, then the output register.
// req_stall is high only while the command queue is full.
// Synchronous reset clears the escape state, the queue pointers and the output valid.

module escape_sequence_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_in_char,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_text_done
);

   escdec_pkg::cmd_type          push_cmd;
   escdec_pkg::cmd_type          head_cmd;
   escdec_pkg::queue_status_type q_status;
   logic                         cmd_push;
   logic                         cmd_pop;

   escdec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .cmd_push        (cmd_push),
      .cmd             (push_cmd)
   );

   escdec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   escdec_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .q_status      (q_status),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_done (rsp_text_done)
   );

endmodule
